// File: src/svd_pkg.sv
package svd_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_B     = 1;
    localparam int CH_F     = 5;
    localparam int CH_ARROW = 7;

    // Fixed move lengths in slow ticks
    localparam logic [15:0] CLEAR_TICKS  = 16'd30;
    localparam logic [15:0] MOVE_H_TICKS = 16'd50;
    localparam logic [15:0] MOVE_V_TICKS = 16'd50;
    localparam logic [15:0] ARROW_TICKS  = 16'd50;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_WAIT       = 4'd1;
    localparam logic [3:0] PH_POWER_ON   = 4'd2;
    localparam logic [3:0] PH_CLEAR      = 4'd3;
    localparam logic [3:0] PH_START_H    = 4'd4;
    localparam logic [3:0] PH_STOP_H     = 4'd5;
    localparam logic [3:0] PH_START_V    = 4'd6;
    localparam logic [3:0] PH_STOP_V     = 4'd7;
    localparam logic [3:0] PH_OFF        = 4'd8;
    localparam logic [3:0] PH_ARROW_ON   = 4'd9;
    localparam logic [3:0] PH_ARROW_MOVE = 4'd10;
    localparam logic [3:0] PH_ARROW_OFF  = 4'd11;

    // Channel groups driven during each move
    localparam logic [7:0] GRP_CLEAR = 8'h22;
    localparam logic [7:0] GRP_HORIZ = 8'h49;
    localparam logic [7:0] GRP_DIGIT = 8'h7F;
    localparam logic [7:0] GRP_ARROW = 8'h80;

    // Operation codes
    localparam logic [2:0] OP_SET_DIGIT = 3'd0;
    localparam logic [2:0] OP_SET_ARROW = 3'd1;
    localparam logic [2:0] OP_FORCE     = 3'd2;
    localparam logic [2:0] OP_SLOW_TICK = 3'd3;
    localparam logic [2:0] OP_FAST_TICK = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_START_DELAY = 3'd1;
    localparam logic [2:0] REG_PWM_PERIOD  = 3'd2;
    localparam logic [2:0] REG_POS_SHOWN   = 3'd3;
    localparam logic [2:0] REG_POS_HIDDEN  = 3'd4;
    localparam logic [2:0] REG_POS_CLEAR   = 3'd5;
    localparam logic [2:0] REG_POWER_ON    = 3'd6;
    localparam logic [2:0] REG_SETTLE      = 3'd7;

    localparam int ADDR_W = 5;

    // Reset values
    localparam logic [11:0] PWM_PERIOD_RST = 12'd200;
    localparam logic [7:0]  POS_SHOWN_RST  = 8'd20;
    localparam logic [7:0]  POS_HIDDEN_RST = 8'd10;
    localparam logic [7:0]  POS_CLEAR_RST  = 8'd15;
    localparam logic [15:0] POWER_ON_RST   = 16'd10;
    localparam logic [15:0] SETTLE_RST     = 16'd10;
    localparam logic [7:0]  LAST_SHOWN_RST = 8'hFF;

    typedef struct packed {
        logic        enable;
        logic [15:0] start_delay;
        logic [11:0] pwm_period;
        logic [7:0]  pos_shown;
        logic [7:0]  pos_hidden;
        logic [7:0]  pos_clear;
        logic [15:0] power_on_ticks;
        logic [15:0] settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] digit_value;
        logic       arrow_on;
        logic [7:0] channel_mask;
        logic [7:0] forced_position;
    } t_item;

    typedef struct packed {
        logic [7:0] servo_lines;
        logic       servo_power;
        logic       update_done;
        logic       busy_res;
        logic [7:0] shown_value;
        logic       arrow_state;
    } t_result;

    // Hex digit to segments A..G; anything above fifteen is blank
    function automatic logic [6:0] seg_lookup(input logic [7:0] v);
        logic [6:0] s;
        begin
            case (v[3:0])
                4'h0: s = 7'h3F;
                4'h1: s = 7'h06;
                4'h2: s = 7'h5B;
                4'h3: s = 7'h4F;
                4'h4: s = 7'h66;
                4'h5: s = 7'h6D;
                4'h6: s = 7'h7D;
                4'h7: s = 7'h07;
                4'h8: s = 7'h7F;
                4'h9: s = 7'h6F;
                4'hA: s = 7'h77;
                4'hB: s = 7'h7C;
                4'hC: s = 7'h39;
                4'hD: s = 7'h5E;
                4'hE: s = 7'h79;
                4'hF: s = 7'h71;
                default: s = 7'h00;
            endcase
            if (v[7:4] != 4'd0) begin
                s = 7'h00;
            end
            return s;
        end
    endfunction

endpackage

// File: src/svd_item_if.sv
interface svd_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] digit_value;
    logic       arrow_on;
    logic [7:0] channel_mask;
    logic [7:0] forced_position;

    modport source (
        output valid, op, digit_value, arrow_on, channel_mask, forced_position,
        input  ready
    );
    modport sink (
        input  valid, op, digit_value, arrow_on, channel_mask, forced_position,
        output ready
    );
endinterface

// File: src/svd_result_if.sv
interface svd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] servo_lines;
    logic       servo_power;
    logic       update_done;
    logic       busy_res;
    logic [7:0] shown_value;
    logic       arrow_state;

    modport source (
        output valid, servo_lines, servo_power, update_done, busy_res, shown_value,
               arrow_state,
        input  ready
    );
    modport sink (
        input  valid, servo_lines, servo_power, update_done, busy_res, shown_value,
               arrow_state,
        output ready
    );
endinterface

// File: src/svd_apb_regs.sv
module svd_apb_regs
    import svd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b1;
            r_cfg.start_delay    <= 16'd0;
            r_cfg.pwm_period     <= PWM_PERIOD_RST;
            r_cfg.pos_shown      <= POS_SHOWN_RST;
            r_cfg.pos_hidden     <= POS_HIDDEN_RST;
            r_cfg.pos_clear      <= POS_CLEAR_RST;
            r_cfg.power_on_ticks <= POWER_ON_RST;
            r_cfg.settle_ticks   <= SETTLE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE:      r_cfg.enable         <= pwdata[0];
                REG_START_DELAY: r_cfg.start_delay    <= pwdata[15:0];
                REG_PWM_PERIOD:  r_cfg.pwm_period     <= pwdata[11:0];
                REG_POS_SHOWN:   r_cfg.pos_shown      <= pwdata[7:0];
                REG_POS_HIDDEN:  r_cfg.pos_hidden     <= pwdata[7:0];
                REG_POS_CLEAR:   r_cfg.pos_clear      <= pwdata[7:0];
                REG_POWER_ON:    r_cfg.power_on_ticks <= pwdata[15:0];
                REG_SETTLE:      r_cfg.settle_ticks   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_ENABLE:      prdata = {31'd0, r_cfg.enable};
            REG_START_DELAY: prdata = {16'd0, r_cfg.start_delay};
            REG_PWM_PERIOD:  prdata = {20'd0, r_cfg.pwm_period};
            REG_POS_SHOWN:   prdata = {24'd0, r_cfg.pos_shown};
            REG_POS_HIDDEN:  prdata = {24'd0, r_cfg.pos_hidden};
            REG_POS_CLEAR:   prdata = {24'd0, r_cfg.pos_clear};
            REG_POWER_ON:    prdata = {16'd0, r_cfg.power_on_ticks};
            REG_SETTLE:      prdata = {16'd0, r_cfg.settle_ticks};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// File: src/svd_core.sv
module svd_core
    import svd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    logic [3:0]  r_next_phase, n_next_phase;
    logic [3:0]  r_cur_phase,  n_cur_phase;
    logic [15:0] r_phase_cnt,  n_phase_cnt;
    logic [7:0]  r_target [CHANNELS];
    logic [7:0]  n_target [CHANNELS];
    logic [7:0]  r_pulse  [CHANNELS];
    logic [7:0]  n_pulse  [CHANNELS];
    logic [11:0] r_period, n_period;
    logic [7:0]  r_group,  n_group;
    logic [7:0]  r_lines,  n_lines;
    logic        r_power,  n_power;
    logic        r_run,    n_run;
    logic [7:0]  r_held,   n_held;
    logic [7:0]  r_last,   n_last;
    logic        r_arrow,  n_arrow;
    logic [7:0]  r_saved_b, n_saved_b;
    logic [7:0]  r_saved_f, n_saved_f;
    logic        n_done;

    // next-state logic for one word
    always_comb begin
        logic [6:0] seg;
        logic [7:0] on_bits;
        logic       drive;
        logic       bit_on;
        n_next_phase = r_next_phase;
        n_cur_phase  = r_cur_phase;
        n_phase_cnt  = r_phase_cnt;
        n_target     = r_target;
        n_pulse      = r_pulse;
        n_period     = r_period;
        n_group      = r_group;
        n_lines      = r_lines;
        n_power      = r_power;
        n_run        = r_run;
        n_held       = r_held;
        n_last       = r_last;
        n_arrow      = r_arrow;
        n_saved_b    = r_saved_b;
        n_saved_f    = r_saved_f;
        n_done       = 1'b0;
        seg          = seg_lookup(i_item.digit_value);
        // arrow channel on top of the digit segments
        on_bits      = {r_arrow, seg};
        drive        = (r_cur_phase == PH_CLEAR) || (r_cur_phase == PH_START_H) ||
                       (r_cur_phase == PH_START_V) || (r_cur_phase == PH_ARROW_MOVE);
        bit_on       = 1'b0;

        if (i_step && i_cfg.enable) begin
            case (i_item.op)
                OP_SET_DIGIT: begin
                    if (i_item.digit_value != r_last) begin
                        n_held = i_item.digit_value;
                        if (r_next_phase == PH_IDLE) begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                bit_on = on_bits[c];
                                n_target[c] = bit_on ? i_cfg.pos_shown : i_cfg.pos_hidden;
                            end
                            n_next_phase = PH_WAIT;
                            n_phase_cnt  = i_cfg.start_delay;
                            n_run        = 1'b1;
                        end
                    end else begin
                        n_done = 1'b1;
                    end
                end
                OP_SET_ARROW: begin
                    if (i_item.arrow_on != r_arrow) begin
                        n_arrow = i_item.arrow_on;
                        n_target[CH_ARROW] = i_item.arrow_on ? i_cfg.pos_shown
                                                             : i_cfg.pos_hidden;
                        if (r_next_phase == PH_IDLE) begin
                            n_next_phase = PH_ARROW_ON;
                            n_phase_cnt  = i_cfg.power_on_ticks;
                            n_run        = 1'b1;
                        end
                    end
                end
                OP_FORCE: begin
                    if (r_next_phase == PH_IDLE) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (i_item.channel_mask[c]) begin
                                n_target[c] = i_item.forced_position;
                            end
                        end
                        n_group      = i_item.channel_mask;
                        n_next_phase = PH_WAIT;
                        n_phase_cnt  = i_cfg.start_delay;
                        n_run        = 1'b1;
                    end
                end
                OP_SLOW_TICK: begin
                    if (r_next_phase != PH_IDLE) begin
                        if (r_phase_cnt != 16'd0) begin
                            n_phase_cnt = r_phase_cnt - 16'd1;
                        end else begin
                            n_cur_phase = r_next_phase;
                            case (r_next_phase)
                                PH_WAIT: begin
                                    n_phase_cnt  = i_cfg.power_on_ticks;
                                    n_next_phase = PH_POWER_ON;
                                end
                                PH_POWER_ON: begin
                                    n_power      = 1'b1;
                                    n_phase_cnt  = i_cfg.power_on_ticks;
                                    n_next_phase = PH_CLEAR;
                                end
                                PH_CLEAR: begin
                                    n_saved_b      = r_target[CH_B];
                                    n_saved_f      = r_target[CH_F];
                                    n_target[CH_B] = i_cfg.pos_clear;
                                    n_target[CH_F] = i_cfg.pos_clear;
                                    n_group        = GRP_CLEAR;
                                    n_phase_cnt    = CLEAR_TICKS;
                                    n_next_phase   = PH_START_H;
                                end
                                PH_START_H: begin
                                    n_target[CH_B] = r_saved_b;
                                    n_target[CH_F] = r_saved_f;
                                    n_group        = GRP_HORIZ;
                                    n_phase_cnt    = MOVE_H_TICKS;
                                    n_next_phase   = PH_STOP_H;
                                end
                                PH_STOP_H: begin
                                    n_phase_cnt  = i_cfg.settle_ticks;
                                    n_next_phase = PH_START_V;
                                end
                                PH_START_V: begin
                                    n_phase_cnt  = MOVE_V_TICKS;
                                    n_group      = GRP_DIGIT;
                                    n_next_phase = PH_STOP_V;
                                end
                                PH_STOP_V: begin
                                    n_last       = r_held;
                                    n_phase_cnt  = i_cfg.settle_ticks;
                                    n_next_phase = (i_cfg.start_delay == 16'd0) ? PH_ARROW_ON
                                                                                 : PH_OFF;
                                end
                                PH_OFF: begin
                                    n_run        = 1'b0;
                                    n_power      = 1'b0;
                                    n_next_phase = PH_IDLE;
                                    n_done       = 1'b1;
                                end
                                PH_ARROW_ON: begin
                                    n_power      = 1'b1;
                                    n_phase_cnt  = i_cfg.power_on_ticks;
                                    n_next_phase = PH_ARROW_MOVE;
                                end
                                PH_ARROW_MOVE: begin
                                    n_group      = GRP_ARROW;
                                    n_phase_cnt  = ARROW_TICKS;
                                    n_next_phase = PH_ARROW_OFF;
                                end
                                PH_ARROW_OFF: begin
                                    n_run        = 1'b0;
                                    n_power      = 1'b0;
                                    n_next_phase = PH_IDLE;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                OP_FAST_TICK: begin
                    if (r_run) begin
                        if (r_period != 12'd0) begin
                            // inside the period: count pulses down, drop finished lines
                            n_period = r_period - 12'd1;
                            for (int c = 0; c < CHANNELS; c++) begin
                                if (r_group[c]) begin
                                    if (r_pulse[c] != 8'd0) begin
                                        n_pulse[c] = r_pulse[c] - 8'd1;
                                    end else begin
                                        n_pulse[c] = r_target[c];
                                        n_lines[c] = 1'b0;
                                    end
                                end
                            end
                        end else begin
                            // period reload: restart pulses, raise lines while moving
                            n_period = i_cfg.pwm_period;
                            for (int c = 0; c < CHANNELS; c++) begin
                                if (r_group[c]) begin
                                    n_pulse[c] = r_target[c];
                                    if (drive) begin
                                        n_lines[c] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result word reflects the state after this update
    always_comb begin
        o_res.servo_lines = n_lines;
        o_res.servo_power = n_power;
        o_res.update_done = n_done;
        o_res.busy_res    = (n_next_phase != PH_IDLE);
        o_res.shown_value = n_held;
        o_res.arrow_state = n_arrow;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_phase <= PH_IDLE;
            r_cur_phase  <= PH_IDLE;
            r_phase_cnt  <= 16'd0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_target[c] <= POS_SHOWN_RST;
                r_pulse[c]  <= 8'd0;
            end
            r_period  <= PWM_PERIOD_RST;
            r_group   <= 8'd0;
            r_lines   <= 8'd0;
            r_power   <= 1'b0;
            r_run     <= 1'b0;
            r_held    <= 8'd0;
            r_last    <= LAST_SHOWN_RST;
            r_arrow   <= 1'b0;
            r_saved_b <= 8'd0;
            r_saved_f <= 8'd0;
        end else begin
            r_next_phase <= n_next_phase;
            r_cur_phase  <= n_cur_phase;
            r_phase_cnt  <= n_phase_cnt;
            r_target     <= n_target;
            r_pulse      <= n_pulse;
            r_period     <= n_period;
            r_group      <= n_group;
            r_lines      <= n_lines;
            r_power      <= n_power;
            r_run        <= n_run;
            r_held       <= n_held;
            r_last       <= n_last;
            r_arrow      <= n_arrow;
            r_saved_b    <= n_saved_b;
            r_saved_f    <= n_saved_f;
        end
    end

endmodule

// File: src/servo_segment_display_sequencer.sv
// Channel    Dir  Handshake      Word
// i_item     in   valid/ready    op, digit_value, arrow_on, channel_mask, forced_position
// o_result   out  valid/ready    servo_lines, servo_power, update_done, busy_res,
//                                shown_value, arrow_state
// APB        in   psel/penable   8 registers at byte address 4*index, pready tied high
//
// One word per cycle sustained while results are read. An accepted word sits in the
// input register until the result slot is free or being drained, is applied to the
// state and lands in the result register. The input register and the result register
// form a two-entry pipe, so a new word is taken while a result waits to be read; input
// stalls only when both are full. Synchronous active-low reset clears the sequencer,
// PWM counters and both pipe stages.
module servo_segment_display_sequencer
    import svd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    svd_item_if.sink          i_item,
    svd_result_if.source      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    t_result w_res;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    w_adv;

    svd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    svd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_cfg   (w_cfg),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    // word moves on when the result slot is free or being drained
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.op              <= i_item.op;
            r_in.digit_value     <= i_item.digit_value;
            r_in.arrow_on        <= i_item.arrow_on;
            r_in.channel_mask    <= i_item.channel_mask;
            r_in.forced_position <= i_item.forced_position;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.servo_lines = r_out.servo_lines;
    assign o_result.servo_power = r_out.servo_power;
    assign o_result.update_done = r_out.update_done;
    assign o_result.busy_res    = r_out.busy_res;
    assign o_result.shown_value = r_out.shown_value;
    assign o_result.arrow_state = r_out.arrow_state;

endmodule
